// ----- rtl/rbe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared constants, types and helpers of the rigid body Euler step pipeline.
// ----------------------------------------------------------------------------
package rbe_pkg;

  // action codes
  localparam logic ActTrans = 1'b0;
  localparam logic ActRot   = 1'b1;

  // step register reset, about 0.01 s in Q0.32
  localparam logic [31:0] DtReset = 32'd42949673;

  // pipeline depths
  localparam int unsigned FrontStages = 6;
  localparam int unsigned IsqrtSteps  = 32;
  localparam int unsigned IsqrtTop    = 2 * IsqrtSteps - 2;
  localparam int unsigned DivSteps    = 32;
  localparam int unsigned DivStages   = DivSteps + 1;
  localparam int unsigned NumQ        = 4;

  localparam logic [31:0] MaxW = 32'h7FFF_FFFF;
  localparam logic [31:0] MinW = 32'h8000_0000;

  localparam logic signed [75:0] SatMax = 76'sd2147483647;
  localparam logic signed [75:0] SatMin = -76'sd2147483648;

  // quaternion as w, x, y, z in slices 0 to 3
  typedef logic [NumQ-1:0][31:0] quat_t;
  // angular rate as x, y, z in slices 0 to 2
  typedef logic [2:0][31:0] rate_t;

  // fields that travel alongside the datapath
  typedef struct packed {
    logic        action;
    logic        active;
    logic [31:0] pos;
    logic [31:0] vel;
    quat_t       quat;
  } side_t;

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [75:0] x);
    logic [31:0] r;
    if (x > SatMax) begin
      r = MaxW;
    end else if (x < SatMin) begin
      r = MinW;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rbe_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_in_if
// Input channel: one body part per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbe_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic               active;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] acceleration;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;

  modport source (
    output valid, action, active, position, velocity, acceleration,
    output quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
    input  ready
  );
  modport sink (
    input  valid, action, active, position, velocity, acceleration,
    input  quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/rbe_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_out_if
// Result channel: one result per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_position;
  logic signed [31:0] new_velocity;
  logic signed [31:0] new_quat_w;
  logic signed [31:0] new_quat_x;
  logic signed [31:0] new_quat_y;
  logic signed [31:0] new_quat_z;

  modport source (
    output valid, new_position, new_velocity,
    output new_quat_w, new_quat_x, new_quat_y, new_quat_z,
    input  ready
  );
  modport sink (
    input  valid, new_position, new_velocity,
    input  new_quat_w, new_quat_x, new_quat_y, new_quat_z,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/rbe_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_front
// Six-stage front end: translation update, quaternion advance and norm squared.
// ----------------------------------------------------------------------------
module rbe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [31:0]    dt_i,
  input  logic           valid_i,
  input  rbe_pkg::side_t side_i,
  input  logic [31:0]    accel_i,
  input  rbe_pkg::rate_t rate_i,
  output logic           valid_o,
  output rbe_pkg::side_t side_o,
  output rbe_pkg::quat_t qn_o,
  output logic [63:0]    n2_o
);
  import rbe_pkg::*;

  logic [FrontStages-1:0] vld_q;
  side_t                  side_q [FrontStages];

  // stage 1
  logic signed [64:0] prod_a_d, prod_a_q;
  logic signed [63:0] rq_d [3][NumQ];
  logic signed [63:0] rq_q [3][NumQ];
  // stage 2
  logic signed [41:0] s_d [NumQ];
  logic signed [41:0] s_q [NumQ];
  side_t              side2_d;
  // stage 3
  logic signed [64:0] prod_v_d, prod_v_q;
  logic signed [58:0] ph_d [NumQ];
  logic signed [58:0] ph_q [NumQ];
  logic signed [58:0] pl_d [NumQ];
  logic signed [58:0] pl_q [NumQ];
  // stage 4
  quat_t              qn4_d, qn4_q;
  side_t              side4_d;
  // stage 5
  logic [61:0]        sq_d [NumQ];
  logic [61:0]        sq_q [NumQ];
  quat_t              qn5_q;
  // stage 6
  logic [63:0]        n2_d, n2_q;
  quat_t              qn6_q;

  // stage 1: acceleration times step, rate times quaternion products
  always_comb begin
    prod_a_d = $signed(accel_i) * $signed({1'b0, dt_i});
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < NumQ; c++) begin
        rq_d[r][c] = $signed(rate_i[r]) * $signed(side_i.quat[c]);
      end
    end
  end

  // stage 2: new velocity, rounded rate products summed per component
  always_comb begin
    logic signed [64:0] ra;
    logic signed [75:0] vsum;
    logic signed [63:0] t;
    logic signed [41:0] rr [3][NumQ];
    ra   = (prod_a_q + 65'sd2147483648) >>> 32;
    vsum = $signed(side_q[0].vel);
    vsum = vsum + ra;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < NumQ; c++) begin
        t        = (rq_q[r][c] + 64'sd8388608) >>> 24;
        rr[r][c] = t[41:0];
      end
    end
    s_d[0] = -(rr[0][1] + rr[1][2] + rr[2][3]);
    s_d[1] = rr[0][0] + rr[1][3] - rr[2][2];
    s_d[2] = -rr[0][3] + rr[1][0] + rr[2][1];
    s_d[3] = rr[0][2] - rr[1][1] + rr[2][0];
    side2_d = side_q[0];
    if (side_q[0].active) begin
      side2_d.vel = sat32(vsum);
    end
  end

  // stage 3: velocity times step, half-split step products
  always_comb begin
    prod_v_d = $signed(side_q[1].vel) * $signed({1'b0, dt_i});
    for (int i = 0; i < NumQ; i++) begin
      ph_d[i] = s_q[i] * $signed({1'b0, dt_i[31:16]});
      pl_d[i] = s_q[i] * $signed({1'b0, dt_i[15:0]});
    end
  end

  // stage 4: new position, advanced quaternion
  always_comb begin
    logic signed [64:0] re;
    logic signed [75:0] psum;
    logic signed [75:0] full;
    logic signed [75:0] qsum;
    re   = (prod_v_q + 65'sd2147483648) >>> 32;
    psum = $signed(side_q[2].pos);
    psum = psum + re;
    side4_d = side_q[2];
    if (side_q[2].active) begin
      side4_d.pos = sat32(psum);
    end
    for (int i = 0; i < NumQ; i++) begin
      full     = ph_q[i];
      full     = (full <<< 16) + pl_q[i] + 76'sd4294967296;
      full     = full >>> 33;
      qsum     = $signed(side_q[2].quat[i]);
      qsum     = qsum + full;
      qn4_d[i] = sat32(qsum);
    end
  end

  // stage 5: squares, quartered
  always_comb begin
    logic signed [63:0] sq;
    for (int i = 0; i < NumQ; i++) begin
      sq      = $signed(qn4_q[i]) * $signed(qn4_q[i]);
      sq_d[i] = sq[63:2];
    end
  end

  // stage 6: norm squared
  always_comb begin
    n2_d = '0;
    for (int i = 0; i < NumQ; i++) begin
      n2_d = n2_d + 64'(sq_q[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FrontStages-2:0], valid_i};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      prod_a_q  <= prod_a_d;
      rq_q      <= rq_d;
      side_q[1] <= side2_d;
      s_q       <= s_d;
      side_q[2] <= side_q[1];
      prod_v_q  <= prod_v_d;
      ph_q      <= ph_d;
      pl_q      <= pl_d;
      side_q[3] <= side4_d;
      qn4_q     <= qn4_d;
      side_q[4] <= side_q[3];
      sq_q      <= sq_d;
      qn5_q     <= qn4_q;
      side_q[5] <= side_q[4];
      n2_q      <= n2_d;
      qn6_q     <= qn5_q;
    end
  end

  assign valid_o = vld_q[FrontStages-1];
  assign side_o  = side_q[FrontStages-1];
  assign qn_o    = qn6_q;
  assign n2_o    = n2_q;

endmodule
`default_nettype wire

// ----- rtl/rbe_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_isqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rbe_isqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [63:0]    n2_i,
  input  rbe_pkg::side_t side_i,
  input  rbe_pkg::quat_t qn_i,
  output logic           valid_o,
  output logic [31:0]    norm_o,
  output logic           zero_o,
  output rbe_pkg::side_t side_o,
  output rbe_pkg::quat_t qn_o
);
  import rbe_pkg::*;

  logic [IsqrtSteps-1:0] vld_q;
  logic [IsqrtSteps-1:0] zero_q;
  logic [63:0]           rem_d [IsqrtSteps];
  logic [63:0]           rem_q [IsqrtSteps];
  logic [63:0]           res_d [IsqrtSteps];
  logic [63:0]           res_q [IsqrtSteps];
  side_t                 side_q [IsqrtSteps];
  quat_t                 qn_q [IsqrtSteps];

  // one trial subtraction per stage
  always_comb begin
    logic [63:0] r_in;
    logic [63:0] s_in;
    logic [63:0] bit_v;
    logic [63:0] trial;
    for (int k = 0; k < IsqrtSteps; k++) begin
      if (k == 0) begin
        r_in = n2_i;
        s_in = '0;
      end else begin
        r_in = rem_q[k-1];
        s_in = res_q[k-1];
      end
      bit_v = 64'd1 << (IsqrtTop - 2 * k);
      trial = s_in + bit_v;
      if (r_in >= trial) begin
        rem_d[k] = r_in - trial;
        res_d[k] = (s_in >> 1) + bit_v;
      end else begin
        rem_d[k] = r_in;
        res_d[k] = s_in >> 1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[IsqrtSteps-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < IsqrtSteps; k++) begin
        rem_q[k] <= rem_d[k];
        res_q[k] <= res_d[k];
        if (k == 0) begin
          side_q[k] <= side_i;
          qn_q[k]   <= qn_i;
          zero_q[k] <= (n2_i == 64'd0);
        end else begin
          side_q[k] <= side_q[k-1];
          qn_q[k]   <= qn_q[k-1];
          zero_q[k] <= zero_q[k-1];
        end
      end
    end
  end

  assign valid_o = vld_q[IsqrtSteps-1];
  assign norm_o  = res_q[IsqrtSteps-1][31:0];
  assign zero_o  = zero_q[IsqrtSteps-1];
  assign side_o  = side_q[IsqrtSteps-1];
  assign qn_o    = qn_q[IsqrtSteps-1];

endmodule
`default_nettype wire

// ----- rtl/rbe_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_div
// Four-lane pipelined restoring divider for the rounded normalisation.
// ----------------------------------------------------------------------------
module rbe_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [31:0]           norm_i,
  input  logic                  zero_i,
  input  rbe_pkg::side_t        side_i,
  input  rbe_pkg::quat_t        qn_i,
  output logic                  valid_o,
  output rbe_pkg::quat_t        quot_o,
  output logic [rbe_pkg::NumQ-1:0] neg_o,
  output logic [rbe_pkg::NumQ-1:0] ovf_o,
  output logic                  zero_o,
  output rbe_pkg::side_t        side_o
);
  import rbe_pkg::*;

  logic [DivStages-1:0] vld_q;
  logic [DivStages-1:0] zero_q;
  logic [63:0]          rem_d [DivStages][NumQ];
  logic [63:0]          rem_q [DivStages][NumQ];
  quat_t                quot_d [DivStages];
  quat_t                quot_q [DivStages];
  logic [NumQ-1:0]      neg_d, ovf_d;
  logic [NumQ-1:0]      neg_q [DivStages];
  logic [NumQ-1:0]      ovf_q [DivStages];
  logic [31:0]          norm_q [DivStages];
  side_t                side_q [DivStages];

  // entry: magnitude, rounded numerator, overflow check; then one quotient bit a stage
  always_comb begin
    logic [31:0] qv;
    logic [32:0] mag;
    logic [63:0] num;
    logic [63:0] trial;
    for (int j = 0; j < NumQ; j++) begin
      qv       = qn_i[j];
      neg_d[j] = qv[31];
      mag      = qv[31] ? ({1'b0, ~qv} + 33'd1) : {1'b0, qv};
      num      = (64'(mag) << 29) + 64'(norm_i >> 1);
      ovf_d[j] = (num >= {norm_i, 32'd0});
      rem_d[0][j]  = num;
      quot_d[0][j] = '0;
    end
    for (int k = 1; k < DivStages; k++) begin
      for (int j = 0; j < NumQ; j++) begin
        trial = 64'(norm_q[k-1]) << (DivSteps - k);
        if (rem_q[k-1][j] >= trial) begin
          rem_d[k][j]  = rem_q[k-1][j] - trial;
          quot_d[k][j] = quot_q[k-1][j] | (32'd1 << (DivSteps - k));
        end else begin
          rem_d[k][j]  = rem_q[k-1][j];
          quot_d[k][j] = quot_q[k-1][j];
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivStages-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
      for (int k = 0; k < DivStages; k++) begin
        if (k == 0) begin
          neg_q[k]  <= neg_d;
          ovf_q[k]  <= ovf_d;
          norm_q[k] <= norm_i;
          zero_q[k] <= zero_i;
          side_q[k] <= side_i;
        end else begin
          neg_q[k]  <= neg_q[k-1];
          ovf_q[k]  <= ovf_q[k-1];
          norm_q[k] <= norm_q[k-1];
          zero_q[k] <= zero_q[k-1];
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  assign valid_o = vld_q[DivStages-1];
  assign quot_o  = quot_q[DivStages-1];
  assign neg_o   = neg_q[DivStages-1];
  assign ovf_o   = ovf_q[DivStages-1];
  assign zero_o  = zero_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule
`default_nettype wire

// ----- rtl/rigid_body_euler_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_body_euler_step
// Semi-implicit Euler step for one body part per transfer, fixed point.
// ----------------------------------------------------------------------------
// Accepts one item every cycle unless a result is held at the output, and
// returns one result per item, in order, after six front stages (translation
// update, quaternion advance, norm squared), 32 square root stages, one divider
// set-up stage, 32 divider stages and the output register. The whole pipeline
// holds while a result waits at the output, so input ready is low only when
// the output register is full and not being taken. The step register may be
// written only while no item is in flight.
module rigid_body_euler_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rbe_in_if.sink      in_ch,
  rbe_out_if.source   out_ch
);
  import rbe_pkg::*;

  logic        en;
  logic [31:0] dt_q;

  side_t       side_in;
  rate_t       rate_in;

  logic        fr_valid;
  side_t       fr_side;
  quat_t       fr_qn;
  logic [63:0] fr_n2;

  logic        sq_valid;
  logic [31:0] sq_norm;
  logic        sq_zero;
  side_t       sq_side;
  quat_t       sq_qn;

  logic            dv_valid;
  quat_t           dv_quot;
  logic [NumQ-1:0] dv_neg;
  logic [NumQ-1:0] dv_ovf;
  logic            dv_zero;
  side_t           dv_side;

  logic        out_vld_q;
  logic [31:0] pos_d, pos_q, vel_d, vel_q;
  quat_t       quat_d, quat_q;

  // step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= DtReset;
    end else if (cfg_we_i) begin
      dt_q <= cfg_wdata_i;
    end
  end

  // pipeline advances unless the output register is held
  assign en          = !out_vld_q || out_ch.ready;
  assign in_ch.ready = en;

  // gather input fields
  always_comb begin
    side_in.action  = in_ch.action;
    side_in.active  = in_ch.active;
    side_in.pos     = in_ch.position;
    side_in.vel     = in_ch.velocity;
    side_in.quat[0] = in_ch.quat_w;
    side_in.quat[1] = in_ch.quat_x;
    side_in.quat[2] = in_ch.quat_y;
    side_in.quat[3] = in_ch.quat_z;
    rate_in[0]      = in_ch.rate_x;
    rate_in[1]      = in_ch.rate_y;
    rate_in[2]      = in_ch.rate_z;
  end

  rbe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .dt_i    (dt_q),
    .valid_i (in_ch.valid),
    .side_i  (side_in),
    .accel_i (in_ch.acceleration),
    .rate_i  (rate_in),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .qn_o    (fr_qn),
    .n2_o    (fr_n2)
  );

  rbe_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .n2_i    (fr_n2),
    .side_i  (fr_side),
    .qn_i    (fr_qn),
    .valid_o (sq_valid),
    .norm_o  (sq_norm),
    .zero_o  (sq_zero),
    .side_o  (sq_side),
    .qn_o    (sq_qn)
  );

  rbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .norm_i  (sq_norm),
    .zero_i  (sq_zero),
    .side_i  (sq_side),
    .qn_i    (sq_qn),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .neg_o   (dv_neg),
    .ovf_o   (dv_ovf),
    .zero_o  (dv_zero),
    .side_o  (dv_side)
  );

  // result selection and quotient saturation
  always_comb begin
    pos_d  = '0;
    vel_d  = '0;
    quat_d = '0;
    if (dv_side.action == ActTrans) begin
      pos_d = dv_side.pos;
      vel_d = dv_side.vel;
    end else if (!dv_side.active || dv_zero) begin
      quat_d = dv_side.quat;
    end else begin
      for (int j = 0; j < NumQ; j++) begin
        if (dv_ovf[j]) begin
          quat_d[j] = dv_neg[j] ? MinW : MaxW;
        end else if (dv_neg[j]) begin
          quat_d[j] = (dv_quot[j] > MinW) ? MinW : (32'd0 - dv_quot[j]);
        end else begin
          quat_d[j] = dv_quot[j][31] ? MaxW : dv_quot[j];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q  <= pos_d;
      vel_q  <= vel_d;
      quat_q <= quat_d;
    end
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.new_position = pos_q;
  assign out_ch.new_velocity = vel_q;
  assign out_ch.new_quat_w   = quat_q[0];
  assign out_ch.new_quat_x   = quat_q[1];
  assign out_ch.new_quat_y   = quat_q[2];
  assign out_ch.new_quat_z   = quat_q[3];

endmodule
`default_nettype wire

// ----- rtl/rbe_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_checker
// Port-level checks of the Euler step block, bound to the top level.
// ----------------------------------------------------------------------------
module rbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] pos_i,
  input logic [31:0] vel_i,
  input logic [31:0] qw_i,
  input logic [31:0] qx_i,
  input logic [31:0] qy_i,
  input logic [31:0] qz_i
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a held result keeps its position, w and z values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pos_i) && $stable(qw_i) && $stable(qz_i))
    else $error("result changed while stalled");

  // an empty output never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // rotation results carry zero translation fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (qw_i != 0 || qx_i != 0 || qy_i != 0 || qz_i != 0)
      |-> pos_i == 0 && vel_i == 0)
    else $error("mixed translation and rotation result");

endmodule

bind rigid_body_euler_step rbe_checker u_rbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .pos_i       (out_ch.new_position),
  .vel_i       (out_ch.new_velocity),
  .qw_i        (out_ch.new_quat_w),
  .qx_i        (out_ch.new_quat_x),
  .qy_i        (out_ch.new_quat_y),
  .qz_i        (out_ch.new_quat_z)
);
`default_nettype wire
